@@ sv/rsi_pkg.sv @@
// Package for the ray/sphere intersection block.
// Holds the multiplier limb width and the configuration register indexes.
package rsi_pkg;

   localparam int LIMB_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CENTER_X  = 2'd0,
      CSR_CENTER_Y  = 2'd1,
      CSR_CENTER_Z  = 2'd2,
      CSR_RADIUS_SQ = 2'd3
   } csr_index_type;

endpackage

@@ sv/ray_sphere_intersect.sv @@
// Ray/sphere intersection. SRW is the root width of the discriminant square root
// (75 at the defaults).
// Throughput one request per cycle; the sqrt and divider pipelines set the depth.
// busy stays low; results leave on rsp_valid for one cycle and are never stalled.
// Reset clears the valid pipeline and loads center 0 and radius_sq 1.0.
module ray_sphere_intersect #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COORD_WIDTH-1:0]        req_origin_x,
   input  logic signed [COORD_WIDTH-1:0]        req_origin_y,
   input  logic signed [COORD_WIDTH-1:0]        req_origin_z,
   input  logic signed [COORD_WIDTH-1:0]        req_dir_x,
   input  logic signed [COORD_WIDTH-1:0]        req_dir_y,
   input  logic signed [COORD_WIDTH-1:0]        req_dir_z,
   input  logic signed [COORD_WIDTH-1:0]        req_t_min,
   input  logic signed [COORD_WIDTH-1:0]        req_t_max,
   output logic                                 rsp_valid,
   output logic                                 rsp_hit,
   output logic signed [COORD_WIDTH-1:0]        rsp_t_hit,
   output logic signed [COORD_WIDTH-1:0]        rsp_t_near,
   output logic signed [COORD_WIDTH-1:0]        rsp_t_far,
   input  logic                                 csr_we,
   input  logic [rsi_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [COORD_WIDTH-1:0]               csr_wdata
);

   localparam int W    = COORD_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int PW   = W + 1;
   localparam int AW   = 2 * W + 2;
   localparam int BW   = 2 * W + 3;
   localparam int CW   = 2 * W + F + 4;
   localparam int BBW  = 2 * BW;
   localparam int ACW  = AW + CW;
   localparam int DW   = ((BBW > ACW) ? BBW : ACW) + 1;
   localparam int SIW  = (DW - 1) + ((DW - 1) % 2);
   localparam int SRW  = SIW / 2;
   localparam int NSW  = ((BW > SRW + 1) ? BW : SRW + 1) + 1;
   localparam int NW   = NSW + F;
   localparam int LAT  = 14 + SRW + W;
   localparam logic [W-1:0] RADIUS_RESET = W'(1) << F;

   logic [W-1:0] center_x_ff, center_y_ff, center_z_ff, radius_sq_ff;

   logic                 accept;
   logic signed [PW-1:0] p_ff [0:2];
   logic signed [W-1:0]  d_ff [0:2];
   logic signed [2*W-1:0] dd [0:2];
   logic signed [2*W:0]   pd [0:2];
   logic signed [2*W+1:0] pp [0:2];

   logic signed [AW-1:0] a_ff, a_d4, a_dly;
   logic signed [BW-1:0] b_ff, b_dly;
   logic signed [CW-1:0] c_ff, pp_sum, r_sh;
   logic signed [BBW-1:0] bb;
   logic signed [ACW-1:0] ac;
   logic signed [DW-1:0]  disc_in;
   logic                  miss_in, miss_ff, miss_dly;
   logic [SIW-1:0]        sq_ff;
   logic [SRW-1:0]        root;
   logic signed [NSW-1:0] nb, sx;
   logic signed [NW-1:0]  numn_in, numf_in, numn_ff, numf_ff;
   logic signed [W-1:0]   tn, tf;
   logic [2*W:0]          side_in, side_dly;
   logic                  v_dly;
   logic signed [W-1:0]   tmin_dly, tmax_dly;
   logic                  hit_n, hit_f;

   logic                 rsp_valid_ff, rsp_hit_ff;
   logic signed [W-1:0]  rsp_t_hit_ff, rsp_t_near_ff, rsp_t_far_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         center_z_ff  <= '0;
         radius_sq_ff <= RADIUS_RESET;
      end else if (csr_we) begin
         unique case (rsi_pkg::csr_index_type'(csr_index))
            rsi_pkg::CSR_CENTER_X:  center_x_ff  <= csr_wdata;
            rsi_pkg::CSR_CENTER_Y:  center_y_ff  <= csr_wdata;
            rsi_pkg::CSR_CENTER_Z:  center_z_ff  <= csr_wdata;
            rsi_pkg::CSR_RADIUS_SQ: radius_sq_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      p_ff[0] <= PW'(req_origin_x) - PW'($signed(center_x_ff));
      p_ff[1] <= PW'(req_origin_y) - PW'($signed(center_y_ff));
      p_ff[2] <= PW'(req_origin_z) - PW'($signed(center_z_ff));
      d_ff[0] <= req_dir_x;
      d_ff[1] <= req_dir_y;
      d_ff[2] <= req_dir_z;
   end

   for (genvar i = 0; i < 3; i++) begin : g_axis
      rsi_mul #(.A_WIDTH(W), .B_WIDTH(W)) u_dd (
         .clock(clock), .a(d_ff[i]), .b(d_ff[i]), .product(dd[i])
      );
      rsi_mul #(.A_WIDTH(PW), .B_WIDTH(W)) u_pd (
         .clock(clock), .a(p_ff[i]), .b(d_ff[i]), .product(pd[i])
      );
      rsi_mul #(.A_WIDTH(PW), .B_WIDTH(PW)) u_pp (
         .clock(clock), .a(p_ff[i]), .b(p_ff[i]), .product(pp[i])
      );
   end

   always_comb begin
      pp_sum = CW'(pp[0]) + CW'(pp[1]) + CW'(pp[2]);
      r_sh   = $signed(CW'(radius_sq_ff) << F);
   end

   always_ff @(posedge clock) begin
      a_ff <= AW'(dd[0]) + AW'(dd[1]) + AW'(dd[2]);
      b_ff <= BW'(pd[0]) + BW'(pd[1]) + BW'(pd[2]);
      c_ff <= pp_sum - r_sh;
   end

   rsi_mul #(.A_WIDTH(BW), .B_WIDTH(BW)) u_bb (
      .clock(clock), .a(b_ff), .b(b_ff), .product(bb)
   );
   rsi_mul #(.A_WIDTH(AW), .B_WIDTH(CW)) u_ac (
      .clock(clock), .a(a_ff), .b(c_ff), .product(ac)
   );

   rsi_delay #(.WIDTH(AW), .DEPTH(4)) u_a_d4 (
      .clock(clock), .reset(reset), .din(a_ff), .dout(a_d4)
   );
   rsi_delay #(.WIDTH(AW), .DEPTH(6 + SRW)) u_a_dly (
      .clock(clock), .reset(reset), .din(a_ff), .dout(a_dly)
   );
   rsi_delay #(.WIDTH(BW), .DEPTH(5 + SRW)) u_b_dly (
      .clock(clock), .reset(reset), .din(b_ff), .dout(b_dly)
   );

   always_comb begin
      disc_in = DW'(bb) - DW'(ac);
      miss_in = (a_d4 == '0) || disc_in[DW-1];
   end

   always_ff @(posedge clock) begin
      miss_ff <= miss_in;
      sq_ff   <= miss_in ? '0 : SIW'(disc_in[DW-2:0]);
   end

   rsi_sqrt #(.IN_WIDTH(SIW)) u_sqrt (
      .clock(clock), .radicand(sq_ff), .root(root)
   );

   always_comb begin
      nb      = -NSW'(b_dly);
      sx      = $signed(NSW'(root));
      numn_in = $signed(NW'(nb - sx)) <<< F;
      numf_in = $signed(NW'(nb + sx)) <<< F;
   end

   always_ff @(posedge clock) begin
      numn_ff <= numn_in;
      numf_ff <= numf_in;
   end

   rsi_div #(.NUM_WIDTH(NW), .DEN_WIDTH(AW), .Q_WIDTH(W)) u_div_near (
      .clock(clock), .num(numn_ff), .den($unsigned(a_dly)), .quot(tn)
   );
   rsi_div #(.NUM_WIDTH(NW), .DEN_WIDTH(AW), .Q_WIDTH(W)) u_div_far (
      .clock(clock), .num(numf_ff), .den($unsigned(a_dly)), .quot(tf)
   );

   assign side_in = {accept, req_t_min, req_t_max};

   rsi_delay #(.WIDTH(2 * W + 1), .DEPTH(LAT - 1)) u_side_dly (
      .clock(clock), .reset(reset), .din(side_in), .dout(side_dly)
   );
   rsi_delay #(.WIDTH(1), .DEPTH(2 + SRW + W)) u_miss_dly (
      .clock(clock), .reset(reset), .din(miss_ff), .dout(miss_dly)
   );

   always_comb begin
      v_dly    = side_dly[2*W];
      tmin_dly = $signed(side_dly[2*W-1:W]);
      tmax_dly = $signed(side_dly[W-1:0]);
      hit_n    = (tn >= tmin_dly) && (tn <= tmax_dly);
      hit_f    = (tf >= tmin_dly) && (tf <= tmax_dly);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= v_dly;
      end
   end

   always_ff @(posedge clock) begin
      if (miss_dly) begin
         rsp_hit_ff    <= 1'b0;
         rsp_t_hit_ff  <= '0;
         rsp_t_near_ff <= '0;
         rsp_t_far_ff  <= '0;
      end else begin
         rsp_hit_ff    <= hit_n || hit_f;
         rsp_t_hit_ff  <= hit_n ? tn : (hit_f ? tf : '0);
         rsp_t_near_ff <= tn;
         rsp_t_far_ff  <= tf;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_t_hit  = rsp_t_hit_ff;
   assign rsp_t_near = rsp_t_near_ff;
   assign rsp_t_far  = rsp_t_far_ff;

endmodule

@@ sv/rsi_delay.sv @@
// Fixed-depth delay line for side data and valid bits.
// Standalone; cleared by reset.
module rsi_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            tap_ff[i] <= '0;
         end
      end else begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

@@ sv/rsi_mul.sv @@
// Pipelined signed multiplier built from limb partial products.
// Uses rsi_pkg for the limb width.
module rsi_mul #(
   parameter int A_WIDTH = 32,
   parameter int B_WIDTH = 32
) (
   input  logic                              clock,
   input  logic signed [A_WIDTH-1:0]         a,
   input  logic signed [B_WIDTH-1:0]         b,
   output logic signed [A_WIDTH+B_WIDTH-1:0] product
);

   localparam int L  = rsi_pkg::LIMB_WIDTH;
   localparam int NA = (A_WIDTH + L - 1) / L;
   localparam int NB = (B_WIDTH + L - 1) / L;
   localparam int P  = A_WIDTH + B_WIDTH;
   localparam int SW = (NA + NB) * L;

   logic [A_WIDTH-1:0]  a_abs;
   logic [B_WIDTH-1:0]  b_abs;
   logic [NA*L-1:0]     amag_ff;
   logic [NB*L-1:0]     bmag_ff;
   logic                neg1_ff, neg2_ff, neg3_ff;
   logic [2*L-1:0]      pp_in [0:NA*NB-1];
   logic [2*L-1:0]      pp_ff [0:NA*NB-1];
   logic [SW-1:0]       acc;
   logic [P-1:0]        sum_ff;
   logic signed [P-1:0] product_in, product_ff;

   always_comb begin
      a_abs = a[A_WIDTH-1] ? A_WIDTH'(-a) : A_WIDTH'(a);
      b_abs = b[B_WIDTH-1] ? B_WIDTH'(-b) : B_WIDTH'(b);
   end

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i*NB+j] = amag_ff[i*L +: L] * bmag_ff[j*L +: L];
         end
      end
   end

   always_comb begin
      acc = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            acc = acc + (SW'(pp_ff[i*NB+j]) << (L * (i + j)));
         end
      end
   end

   always_comb begin
      product_in = neg3_ff ? -$signed(sum_ff) : $signed(sum_ff);
   end

   always_ff @(posedge clock) begin
      amag_ff    <= (NA*L)'(a_abs);
      bmag_ff    <= (NB*L)'(b_abs);
      neg1_ff    <= a[A_WIDTH-1] ^ b[B_WIDTH-1];
      pp_ff      <= pp_in;
      neg2_ff    <= neg1_ff;
      sum_ff     <= acc[P-1:0];
      neg3_ff    <= neg2_ff;
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

@@ sv/rsi_sqrt.sv @@
// Pipelined digit-by-digit floor square root, one root bit per stage.
// Standalone.
module rsi_sqrt #(
   parameter int IN_WIDTH = 32
) (
   input  logic                  clock,
   input  logic [IN_WIDTH-1:0]   radicand,
   output logic [IN_WIDTH/2-1:0] root
);

   localparam int RW  = IN_WIDTH / 2;
   localparam int RMW = RW + 3;

   logic [RMW-1:0]      rem_ff  [0:RW-1];
   logic [RW-1:0]       root_ff [0:RW-1];
   logic [IN_WIDTH-1:0] dat_ff  [0:RW-1];

   for (genvar k = 0; k < RW; k++) begin : g_step
      logic [RMW-1:0]      rem_prev, cur, trial, rem_in;
      logic [RW-1:0]       root_prev, root_in;
      logic [IN_WIDTH-1:0] dat_prev;
      logic                ge;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign dat_prev  = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign dat_prev  = dat_ff[k-1];
      end

      always_comb begin
         cur     = {rem_prev[RMW-3:0], dat_prev[IN_WIDTH-1 -: 2]};
         trial   = RMW'({root_prev, 2'b01});
         ge      = cur >= trial;
         rem_in  = ge ? cur - trial : cur;
         root_in = {root_prev[RW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         dat_ff[k]  <= dat_prev << 2;
      end
   end

   assign root = root_ff[RW-1];

endmodule

@@ sv/rsi_div.sv @@
// Pipelined restoring divider, floor quotient saturated to Q_WIDTH signed bits.
// Standalone.
module rsi_div #(
   parameter int NUM_WIDTH = 64,
   parameter int DEN_WIDTH = 32,
   parameter int Q_WIDTH   = 32
) (
   input  logic                        clock,
   input  logic signed [NUM_WIDTH-1:0] num,
   input  logic [DEN_WIDTH-1:0]        den,
   output logic signed [Q_WIDTH-1:0]   quot
);

   localparam int XW = ((NUM_WIDTH > DEN_WIDTH + Q_WIDTH) ?
                        NUM_WIDTH : DEN_WIDTH + Q_WIDTH) + 1;

   logic [NUM_WIDTH-1:0] mag_in;
   logic                 big_in;
   logic [NUM_WIDTH-1:0] rem_ff [0:Q_WIDTH];
   logic [DEN_WIDTH-1:0] den_ff [0:Q_WIDTH];
   logic [Q_WIDTH-1:0]   q_ff   [0:Q_WIDTH];
   logic                 neg_ff [0:Q_WIDTH];
   logic                 big_ff [0:Q_WIDTH];
   logic [Q_WIDTH:0]     qv, qneg;
   logic [Q_WIDTH:0]     lim;

   always_comb begin
      mag_in = num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
      big_in = XW'(mag_in) >= (XW'(den) << Q_WIDTH);
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= mag_in;
      den_ff[0] <= den;
      q_ff[0]   <= '0;
      neg_ff[0] <= num[NUM_WIDTH-1];
      big_ff[0] <= big_in;
   end

   for (genvar s = 1; s <= Q_WIDTH; s++) begin : g_step
      localparam int J = Q_WIDTH - s;
      logic [XW-1:0]        sub;
      logic                 ge;
      logic [NUM_WIDTH-1:0] rem_in;
      logic [Q_WIDTH-1:0]   q_in;

      always_comb begin
         sub    = XW'(den_ff[s-1]) << J;
         ge     = XW'(rem_ff[s-1]) >= sub;
         rem_in = ge ? NUM_WIDTH'(XW'(rem_ff[s-1]) - sub) : rem_ff[s-1];
         q_in    = q_ff[s-1];
         q_in[J] = ge;
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in;
         den_ff[s] <= den_ff[s-1];
         q_ff[s]   <= q_in;
         neg_ff[s] <= neg_ff[s-1];
         big_ff[s] <= big_ff[s-1];
      end
   end

   always_comb begin
      lim  = (Q_WIDTH+1)'(1) << (Q_WIDTH - 1);
      qv   = (Q_WIDTH+1)'(q_ff[Q_WIDTH]) + (Q_WIDTH+1)'(rem_ff[Q_WIDTH] != '0);
      qneg = (Q_WIDTH+1)'(0) - qv;
      if (neg_ff[Q_WIDTH]) begin
         if (big_ff[Q_WIDTH] || qv > lim) begin
            quot = {1'b1, {(Q_WIDTH-1){1'b0}}};
         end else begin
            quot = $signed(qneg[Q_WIDTH-1:0]);
         end
      end else begin
         if (big_ff[Q_WIDTH] || q_ff[Q_WIDTH][Q_WIDTH-1]) begin
            quot = {1'b0, {(Q_WIDTH-1){1'b1}}};
         end else begin
            quot = $signed(q_ff[Q_WIDTH]);
         end
      end
   end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for ray_sphere_intersect: random and directed rays
// against a wide-integer intersection predictor. Depends on rsi_pkg and the RTL.
module testbench;

   typedef logic signed [255:0] big_type;

   typedef struct {
      logic signed [31:0] org [3];
      logic signed [31:0] dir [3];
      logic signed [31:0] t_min;
      logic signed [31:0] t_max;
   } ray_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] t_hit;
      logic signed [31:0] t_near;
      logic signed [31:0] t_far;
   } hit_type;

   class hit_scoreboard;
      logic signed [31:0] center [3];
      logic [31:0]        radius_sq;
      hit_type            pending [$];
      int                 mismatches;

      function new();
         center = '{0, 0, 0};
         radius_sq = 32'h0001_0000;
         mismatches = 0;
      endfunction

      function void write_reg(rsi_pkg::csr_index_type idx, logic [31:0] val);
         case (idx)
            rsi_pkg::CSR_CENTER_X:  center[0] = val;
            rsi_pkg::CSR_CENTER_Y:  center[1] = val;
            rsi_pkg::CSR_CENTER_Z:  center[2] = val;
            rsi_pkg::CSR_RADIUS_SQ: radius_sq = val;
            default: ;
         endcase
      endfunction

      function logic signed [31:0] floor_div_sat(big_type num, big_type den);
         big_type q;
         big_type maxv;
         maxv = 2147483647;
         q = num / den;
         if (num < 0 && q * den != num) q = q - 1;
         if (q > maxv) return 32'sh7fff_ffff;
         if (q < -maxv - 1) return 32'sh8000_0000;
         return q[31:0];
      endfunction

      function void note_ray(ray_type r);
         big_type a, b, pp, c, disc, s, cand, p, d, one;
         hit_type e;
         a = 0; b = 0; pp = 0; one = 1;
         for (int i = 0; i < 3; i++) begin
            p = big_type'(r.org[i]) - big_type'(center[i]);
            d = big_type'(r.dir[i]);
            a = a + d * d;
            b = b + p * d;
            pp = pp + p * p;
         end
         c = pp - ($signed({224'b0, radius_sq}) <<< 16);
         disc = b * b - a * c;
         e = '{1'b0, 0, 0, 0};
         if (a != 0 && disc >= 0) begin
            s = 0;
            for (int k = 79; k >= 0; k--) begin
               cand = s | (one << k);
               if (cand * cand <= disc) s = cand;
            end
            e.t_near = floor_div_sat((-b - s) <<< 16, a);
            e.t_far  = floor_div_sat((-b + s) <<< 16, a);
            if (e.t_near >= r.t_min && e.t_near <= r.t_max) begin
               e.hit = 1'b1;
               e.t_hit = e.t_near;
            end else if (e.t_far >= r.t_min && e.t_far <= r.t_max) begin
               e.hit = 1'b1;
               e.t_hit = e.t_far;
            end
         end
         pending.push_back(e);
      endfunction

      function void check_hit(hit_type got);
         hit_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response hit=%0d t_hit=%0d", got.hit,
                                           got.t_hit);
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp hit=%0d t_hit=%0d near=%0d far=%0d, got %0d %0d %0d %0d",
                        e.hit, e.t_hit, e.t_near, e.t_far,
                        got.hit, got.t_hit, got.t_near, got.t_far);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   ray_type drv;
   logic rsp_valid, rsp_hit;
   logic signed [31:0] rsp_t_hit, rsp_t_near, rsp_t_far;
   logic csr_we = 1'b0;
   rsi_pkg::csr_index_type csr_index = rsi_pkg::CSR_CENTER_X;
   logic [31:0] csr_wdata = '0;
   hit_scoreboard sb = new();
   int idle_count = 0;
   bit idle_on = 1'b1;

   initial drv = '{'{0, 0, 0}, '{0, 0, 0}, 0, 0};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   ray_sphere_intersect dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_origin_x(drv.org[0]), .req_origin_y(drv.org[1]), .req_origin_z(drv.org[2]),
      .req_dir_x(drv.dir[0]), .req_dir_y(drv.dir[1]), .req_dir_z(drv.dir[2]),
      .req_t_min(drv.t_min), .req_t_max(drv.t_max),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_t_hit(rsp_t_hit),
      .rsp_t_near(rsp_t_near), .rsp_t_far(rsp_t_far),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
         if (start && !busy) sb.note_ray(drv);
         if (rsp_valid) sb.check_hit('{rsp_hit, rsp_t_hit, rsp_t_near, rsp_t_far});
         if ((start && !busy) || rsp_valid) idle_count <= 0;
         else idle_count <= idle_count + 1;
         if (idle_count > 5000) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_ray(ray_type r);
      while (idle_on && $urandom_range(99) < 30) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      drv = r;
      start = 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic write_csr(rsi_pkg::csr_index_type idx, logic [31:0] val);
      @(negedge clock);
      start = 1'b0;
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (130) @(negedge clock);
   endtask

   function automatic ray_type make_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz, tn, tx);
      ray_type r;
      r.org = '{ox, oy, oz};
      r.dir = '{dx, dy, dz};
      r.t_min = tn;
      r.t_max = tx;
      return r;
   endfunction

   function automatic ray_type random_ray();
      ray_type r;
      if ($urandom_range(99) < 20) begin
         r.org = '{$urandom, $urandom, $urandom};
         r.dir = '{$urandom, $urandom, $urandom};
         r.t_min = $urandom;
         r.t_max = $urandom;
      end else begin
         for (int i = 0; i < 3; i++) begin
            r.org[i] = sb.center[i] + $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
            r.dir[i] = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
         end
         r.t_min = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
         r.t_max = r.t_min + $signed($urandom_range(32'h0010_0000)) - 32'sh0001_0000;
      end
      return r;
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         idle_on = !(i >= n / 3 && i < n / 3 + 60);
         send_ray(random_ray());
         if (i == n / 2) drain();
      end
      idle_on = 1'b1;
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_ray(make_ray(0, 0, -32'sh0002_0000, 0, 0, 32'sh0001_0000, 0, 32'sh0010_0000));
      send_ray(make_ray(32'sh0001_0000, 0, -32'sh0002_0000, 0, 0, 32'sh0001_0000,
                        0, 32'sh0010_0000));
      send_ray(make_ray(0, 0, 0, 0, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff));
      send_ray(make_ray(0, 0, -32'sh0002_0000, 0, 0, 32'sh0001_0000,
                        32'sh0005_0000, 32'sh0001_0000));
      send_ray(make_ray(0, 0, 0, 0, 0, 32'sh0001_0000, 0, 32'sh0010_0000));
      send_ray(make_ray(0, 0, -32'sh0002_0000, 0, 0, 32'sh0001_0000,
                        32'sh0002_0000, 32'sh0010_0000));
      send_ray(make_ray(0, 0, 32'sh7fff_0000, 0, 0, 1, 32'sh8000_0000, 32'sh7fff_ffff));
      send_ray(make_ray(32'sh0005_0000, 0, 0, 0, 0, 32'sh0001_0000, 0, 32'sh7fff_ffff));
      send_ray(make_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff));
      send_ray(make_ray(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                        32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000));
      send_ray(make_ray(0, 0, 0, 1, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff));
      drain();
      random_phase(300);

      write_csr(rsi_pkg::CSR_CENTER_X, 32'sh0003_0000);
      write_csr(rsi_pkg::CSR_CENTER_Y, -32'sh0001_8000);
      write_csr(rsi_pkg::CSR_CENTER_Z, 32'sh0000_4000);
      write_csr(rsi_pkg::CSR_RADIUS_SQ, 32'h0004_0000);
      random_phase(400);

      write_csr(rsi_pkg::CSR_RADIUS_SQ, 32'h0000_0000);
      send_ray(make_ray(32'sh0003_0000, -32'sh0001_8000, 0, 0, 0, 32'sh0001_0000,
                        32'sh8000_0000, 32'sh7fff_ffff));
      random_phase(200);

      write_csr(rsi_pkg::CSR_CENTER_X, 32'sh7fff_ffff);
      write_csr(rsi_pkg::CSR_CENTER_Y, 32'sh8000_0000);
      write_csr(rsi_pkg::CSR_CENTER_Z, 32'sh7fff_ffff);
      write_csr(rsi_pkg::CSR_RADIUS_SQ, 32'hffff_ffff);
      random_phase(300);

      write_csr(rsi_pkg::CSR_CENTER_X, 32'sh8000_0000);
      write_csr(rsi_pkg::CSR_CENTER_Y, 32'sh7fff_ffff);
      write_csr(rsi_pkg::CSR_CENTER_Z, 32'sh8000_0000);
      write_csr(rsi_pkg::CSR_RADIUS_SQ, $urandom);
      random_phase(300);

      write_csr(rsi_pkg::CSR_CENTER_X, $urandom_range(32'h000f_ffff));
      write_csr(rsi_pkg::CSR_CENTER_Y, $urandom_range(32'h000f_ffff));
      write_csr(rsi_pkg::CSR_CENTER_Z, $urandom_range(32'h000f_ffff));
      write_csr(rsi_pkg::CSR_RADIUS_SQ, $urandom_range(32'h0040_0000));
      random_phase(300);

      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
